// File: sv/iqmix_pkg.sv
// ----------------------------------------------------------------------------
// iqmix_pkg: shared constants and table builders for the I/Q mixer
// Holds the default parameter values, the fixed field widths and the
// elaboration-time functions that build the Q1.15 sine table.
// ----------------------------------------------------------------------------
package iqmix_pkg;

  // Defaults for the top-level parameters.
  localparam int SAMPLE_WIDTH_DEF = 16;
  localparam int PHASE_WIDTH_DEF  = 32;
  localparam int TABLE_BITS_DEF   = 10;

  // Fixed widths of the index field and the step register.
  localparam int INDEX_WIDTH = 32;
  localparam int STEP_WIDTH  = 32;

  // Oscillator samples are Q1.15 with amplitude 32767.
  localparam int          OSC_WIDTH = 16;
  localparam int          FRAC_BITS = OSC_WIDTH - 1;
  localparam logic [63:0] OSC_AMP   = 64'd32767;

  // Q30 constants for the series evaluation.
  localparam logic [63:0] Q30_ONE     = 64'd1 << 30;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  // Sine over the first quarter turn, j in 0 .. quarter, by an order-11
  // Taylor series in Q30 with truncating steps, rounded half up to Q1.15.
  // Only evaluated at elaboration to fill the table.
  function automatic logic [OSC_WIDTH-1:0] quarter_sine(input int j, input int tb);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    logic [63:0] v;
    x  = (64'(j) * HALF_PI_Q30) >> (tb - 2);
    x2 = (x * x) >> 30;
    t  = Q30_ONE - x2 / 64'd110;
    t  = Q30_ONE - ((x2 * t) >> 30) / 64'd72;
    t  = Q30_ONE - ((x2 * t) >> 30) / 64'd42;
    t  = Q30_ONE - ((x2 * t) >> 30) / 64'd20;
    t  = Q30_ONE - ((x2 * t) >> 30) / 64'd6;
    s  = (x * t) >> 30;
    v  = (s * OSC_AMP + (64'd1 << 29)) >> 30;
    if (v > OSC_AMP) begin
      v = OSC_AMP;
    end
    return v[OSC_WIDTH-1:0];
  endfunction

  // Full-turn table entry k, built from the quarter wave by symmetry.
  function automatic logic signed [OSC_WIDTH-1:0] sine_entry(input int k, input int tb);
    int quarter;
    int q;
    int j;
    logic signed [OSC_WIDTH-1:0] v;
    quarter = 1 << (tb - 2);
    q       = (k >> (tb - 2)) & 3;
    j       = k & (quarter - 1);
    case (q)
      0: begin
        v = $signed(quarter_sine(j, tb));
      end
      1: begin
        v = $signed(quarter_sine(quarter - j, tb));
      end
      2: begin
        v = -$signed(quarter_sine(j, tb));
      end
      default: begin
        v = -$signed(quarter_sine(quarter - j, tb));
      end
    endcase
    return v;
  endfunction

endpackage

// File: sv/indexed_oscillator_iq_mixer.sv
// ----------------------------------------------------------------------------
// indexed_oscillator_iq_mixer: complex mixer with an indexed oscillator
// Stages: s1 (table address), s2 (sine and cosine), s3 (products), output register.
// Throughput: one item per clock cycle while out_tready holds; each stage holds one
// item and refills as soon as the stage after it moves on.
// Reset: synchronous, active low; clears all stage valid bits and phase_step.
// The sine table is a constant ROM and needs no fill after reset.
// ----------------------------------------------------------------------------
module indexed_oscillator_iq_mixer
  import iqmix_pkg::*;
#(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
  parameter int PHASE_WIDTH  = PHASE_WIDTH_DEF,
  parameter int TABLE_BITS   = TABLE_BITS_DEF,
  localparam int IN_DW  = ((INDEX_WIDTH + 2 * SAMPLE_WIDTH + 7) / 8) * 8,
  localparam int OUT_DW = ((2 * SAMPLE_WIDTH + 7) / 8) * 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // Configuration: phase step per sample.
  input  logic                  cfg_wr_en,
  input  logic [STEP_WIDTH-1:0] cfg_wr_data,
  // Input stream.
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DW-1:0]      in_tdata,   // sample_index, in_i, in_q, zero pad
  input  logic                  in_tlast,   // terminating
  // Result stream.
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DW-1:0]     out_tdata,  // out_i, out_q, zero pad
  output logic                  out_tlast   // end_of_stream
);

  localparam int SW       = SAMPLE_WIDTH;
  localparam int MUL_W    = (PHASE_WIDTH < INDEX_WIDTH) ? PHASE_WIDTH : INDEX_WIDTH;
  localparam int TBL_SIZE = 1 << TABLE_BITS;
  localparam int PROD_W   = SW + OSC_WIDTH;
  localparam int PSUM_W   = PROD_W + 1;

  localparam logic [TABLE_BITS-1:0] QUARTER = TABLE_BITS'(1 << (TABLE_BITS - 2));
  localparam logic signed [PSUM_W-1:0] RND_BIAS = PSUM_W'(1 << (FRAC_BITS - 1));
  localparam logic signed [PSUM_W-1:0] SAT_MAX  = PSUM_W'((64'd1 << (SW - 1)) - 64'd1);
  localparam logic signed [PSUM_W-1:0] SAT_MIN  = -SAT_MAX - PSUM_W'(1);
  localparam logic signed [OSC_WIDTH-1:0] OSC_MIN = {1'b1, {(OSC_WIDTH - 1){1'b0}}};

  // Configuration register.
  logic [STEP_WIDTH-1:0] phase_step_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_step_r <= '0;
    end else if (cfg_wr_en) begin
      phase_step_r <= cfg_wr_data;
    end
  end

  // Input field unpacking.
  logic [INDEX_WIDTH-1:0] in_index;
  logic signed [SW-1:0]   in_a;
  logic signed [SW-1:0]   in_b;

  assign in_index = in_tdata[INDEX_WIDTH-1:0];
  assign in_a     = $signed(in_tdata[INDEX_WIDTH +: SW]);
  assign in_b     = $signed(in_tdata[INDEX_WIDTH + SW +: SW]);

  // Stage registers.
  logic                    s1_valid_r, s1_valid_nxt;
  logic [TABLE_BITS-1:0]   s1_addr_r;
  logic signed [SW-1:0]    s1_a_r, s1_b_r;
  logic                    s1_last_r;

  logic                    s2_valid_r, s2_valid_nxt;
  logic signed [OSC_WIDTH-1:0] s2_sin_r, s2_cos_r;
  logic signed [SW-1:0]    s2_a_r, s2_b_r;
  logic                    s2_last_r;

  logic                    s3_valid_r, s3_valid_nxt;
  logic signed [PROD_W-1:0] s3_p_as_r, s3_p_bc_r, s3_p_ac_r, s3_p_bs_r;
  logic signed [SW-1:0]    s3_a_r, s3_b_r;
  logic                    s3_last_r;

  logic                    out_valid_r, out_valid_nxt;
  logic signed [SW-1:0]    out_i_r, out_q_r;
  logic                    out_last_r;

  // Per-stage ready: a stage takes a new item when empty or draining.
  logic out_rdy, s3_rdy, s2_rdy, s1_rdy;

  assign out_rdy   = !out_valid_r || out_tready;
  assign s3_rdy    = !s3_valid_r || out_rdy;
  assign s2_rdy    = !s2_valid_r || s3_rdy;
  assign s1_rdy    = !s1_valid_r || s2_rdy;
  assign in_tready = s1_rdy;

  assign s1_valid_nxt  = s1_rdy  ? in_tvalid  : s1_valid_r;
  assign s2_valid_nxt  = s2_rdy  ? s1_valid_r : s2_valid_r;
  assign s3_valid_nxt  = s3_rdy  ? s2_valid_r : s3_valid_r;
  assign out_valid_nxt = out_rdy ? s3_valid_r : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      s2_valid_r  <= s2_valid_nxt;
      s3_valid_r  <= s3_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Stage 1: phase = index * step modulo one turn; keep the table address.
  logic [2*MUL_W-1:0] phase_prod;

  assign phase_prod = (2 * MUL_W)'(in_index[MUL_W-1:0]) *
                      (2 * MUL_W)'(phase_step_r[MUL_W-1:0]);

  always_ff @(posedge clk) begin
    if (s1_rdy && in_tvalid) begin
      s1_addr_r <= phase_prod[PHASE_WIDTH-1 -: TABLE_BITS];
      s1_a_r    <= in_a;
      s1_b_r    <= in_b;
      s1_last_r <= in_tlast;
    end
  end

  // Stage 2: sine ROM with two registered read ports, sine and cosine.
  logic signed [OSC_WIDTH-1:0] sine_rom [TBL_SIZE];

  for (genvar k = 0; k < TBL_SIZE; k++) begin : g_rom
    assign sine_rom[k] = sine_entry(k, TABLE_BITS);
  end

  always_ff @(posedge clk) begin
    if (s2_rdy && s1_valid_r) begin
      s2_sin_r  <= sine_rom[s1_addr_r];
      s2_cos_r  <= sine_rom[s1_addr_r + QUARTER];
      s2_a_r    <= s1_a_r;
      s2_b_r    <= s1_b_r;
      s2_last_r <= s1_last_r;
    end
  end

  // Stage 3: the four partial products of the complex multiply.
  always_ff @(posedge clk) begin
    if (s3_rdy && s2_valid_r) begin
      s3_p_as_r <= PROD_W'(s2_a_r) * PROD_W'(s2_sin_r);
      s3_p_bc_r <= PROD_W'(s2_b_r) * PROD_W'(s2_cos_r);
      s3_p_ac_r <= PROD_W'(s2_a_r) * PROD_W'(s2_cos_r);
      s3_p_bs_r <= PROD_W'(s2_b_r) * PROD_W'(s2_sin_r);
      s3_a_r    <= s2_a_r;
      s3_b_r    <= s2_b_r;
      s3_last_r <= s2_last_r;
    end
  end

  // Stage 4: sum, round half up, saturate; terminating items pass unmixed.
  logic signed [PSUM_W-1:0] sum_i, sum_q, shr_i, shr_q;
  logic signed [SW-1:0]     sat_i, sat_q;

  assign sum_i = PSUM_W'(s3_p_as_r) - PSUM_W'(s3_p_bc_r) + RND_BIAS;
  assign sum_q = PSUM_W'(s3_p_ac_r) + PSUM_W'(s3_p_bs_r) + RND_BIAS;
  assign shr_i = sum_i >>> FRAC_BITS;
  assign shr_q = sum_q >>> FRAC_BITS;

  always_comb begin
    if (shr_i > SAT_MAX) begin
      sat_i = SW'(SAT_MAX);
    end else if (shr_i < SAT_MIN) begin
      sat_i = SW'(SAT_MIN);
    end else begin
      sat_i = SW'(shr_i);
    end
    if (shr_q > SAT_MAX) begin
      sat_q = SW'(SAT_MAX);
    end else if (shr_q < SAT_MIN) begin
      sat_q = SW'(SAT_MIN);
    end else begin
      sat_q = SW'(shr_q);
    end
  end

  always_ff @(posedge clk) begin
    if (out_rdy && s3_valid_r) begin
      out_i_r    <= s3_last_r ? s3_a_r : sat_i;
      out_q_r    <= s3_last_r ? s3_b_r : sat_q;
      out_last_r <= s3_last_r;
    end
  end

  // Result port.
  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DW'({out_q_r, out_i_r});
  assign out_tlast  = out_last_r;

  // A stage that cannot hand on must keep its item.
  a_s2_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_valid_r && !s3_rdy) |=> s2_valid_r)
    else $error("stage 2 item lost while stage 3 was blocked");

  // An empty first stage always accepts.
  a_s1_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_valid_r |-> in_tready)
    else $error("input not ready with stage 1 empty");

  // The table never holds the most negative code.
  a_osc_range: assert property (@(posedge clk) disable iff (!rst_n)
    s2_valid_r |-> (s2_sin_r != OSC_MIN && s2_cos_r != OSC_MIN))
    else $error("oscillator sample out of range");

  // A terminating item reaches the output unmixed.
  a_bypass: assert property (@(posedge clk) disable iff (!rst_n)
    (s3_valid_r && s3_last_r && out_rdy) |=>
      (out_tvalid && out_tlast && out_i_r == $past(s3_a_r) && out_q_r == $past(s3_b_r)))
    else $error("terminating item was altered");

endmodule

// File: verif/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for the indexed-oscillator I/Q mixer
// Streams complex samples through the mixer under random idling on both
// sides and checks every result, against its typed value in the directed
// table or a local model of the oscillator table, rounding and saturation.
// Directed rows first, then random index runs under several phase steps.
// ----------------------------------------------------------------------------
module tb
  import iqmix_pkg::*;
();

  localparam int SW           = 16;
  localparam int TBL_BITS     = 10;
  localparam int TBL_N        = 1 << TBL_BITS;
  localparam int TBL_QTR      = TBL_N / 4;
  localparam int IN_W         = 64;
  localparam int OUT_W        = 32;
  localparam int DRAIN_CYCLES = 8;
  localparam int IDLE_LIMIT   = 2000;
  localparam int N_PHASES     = 6;
  localparam int PHASE_ITEMS  = 135;
  localparam int REPORT_MAX   = 20;

  typedef struct packed {
    logic [INDEX_WIDTH-1:0] index;
    logic signed [SW-1:0]   re;
    logic signed [SW-1:0]   im;
    logic                   last;
  } sample_t;

  typedef struct packed {
    logic signed [SW-1:0] re;
    logic signed [SW-1:0] im;
    logic                 eos;
  } mixed_t;

  typedef struct packed {
    logic                  set_step;
    logic [STEP_WIDTH-1:0] step;
    sample_t               smp;
    logic                  typed;
    mixed_t                res;
  } dir_row_t;

  // Directed items. Rows with typed results run at the reset step of zero,
  // where the oscillator sits at sine 0 and cosine 32767, or are terminating.
  localparam int DIR_N = 22;
  localparam dir_row_t DIR_ROWS [DIR_N] = '{
    '{1'b0, 32'h0, '{32'h0000_0000, 16'h0000, 16'h0000, 1'b0}, 1'b1, '{16'h0000, 16'h0000, 1'b0}},
    '{1'b0, 32'h0, '{32'hFFFF_FFFF, 16'h7FFF, 16'h0000, 1'b0}, 1'b1, '{16'h0000, 16'h7FFE, 1'b0}},
    '{1'b0, 32'h0, '{32'h5555_5555, 16'h8000, 16'h8000, 1'b0}, 1'b1, '{16'h7FFF, 16'h8001, 1'b0}},
    '{1'b0, 32'h0, '{32'hAAAA_AAAA, 16'h0000, 16'h7FFF, 1'b0}, 1'b1, '{16'h8002, 16'h0000, 1'b0}},
    '{1'b0, 32'h0, '{32'h0000_0001, 16'h0001, 16'h0000, 1'b0}, 1'b1, '{16'h0000, 16'h0001, 1'b0}},
    '{1'b0, 32'h0, '{32'h8000_0000, 16'hFFFF, 16'h0000, 1'b0}, 1'b1, '{16'h0000, 16'hFFFF, 1'b0}},
    '{1'b0, 32'h0, '{32'h1234_5678, 16'h0000, 16'h8000, 1'b0}, 1'b1, '{16'h7FFF, 16'h0000, 1'b0}},
    '{1'b0, 32'h0, '{32'h0000_0000, 16'h8000, 16'h7FFF, 1'b1}, 1'b1, '{16'h8000, 16'h7FFF, 1'b1}},
    '{1'b0, 32'h0, '{32'hFFFF_FFFF, 16'h0001, 16'hFFFF, 1'b1}, 1'b1, '{16'h0001, 16'hFFFF, 1'b1}},
    // With a step of one the index is the phase itself.
    '{1'b1, 32'h1, '{32'h4000_0000, 16'h7FFF, 16'h8000, 1'b0}, 1'b0, '0},
    '{1'b0, 32'h1, '{32'h2000_0000, 16'h7FFF, 16'h8000, 1'b0}, 1'b0, '0},
    '{1'b0, 32'h1, '{32'h2000_0000, 16'h8000, 16'h7FFF, 1'b0}, 1'b0, '0},
    '{1'b0, 32'h1, '{32'hA000_0000, 16'h8000, 16'h8000, 1'b0}, 1'b0, '0},
    '{1'b0, 32'h1, '{32'h8000_0000, 16'h1234, 16'hEDCB, 1'b0}, 1'b0, '0},
    '{1'b0, 32'h1, '{32'hC000_0000, 16'h7FFF, 16'h7FFF, 1'b0}, 1'b0, '0},
    '{1'b0, 32'h1, '{32'h003F_FFFF, 16'h4000, 16'hC000, 1'b0}, 1'b0, '0},
    '{1'b0, 32'h1, '{32'h0040_0000, 16'h4000, 16'hC000, 1'b0}, 1'b0, '0},
    '{1'b0, 32'h1, '{32'hFFFF_FFFF, 16'h7FFF, 16'h8000, 1'b0}, 1'b0, '0},
    // Largest step: the product wraps round the full turn.
    '{1'b1, 32'hFFFF_FFFF, '{32'hFFFF_FFFF, 16'h7FFF, 16'h0001, 1'b0}, 1'b0, '0},
    '{1'b0, 32'hFFFF_FFFF, '{32'h0000_0400, 16'h8000, 16'h7FFF, 1'b0}, 1'b0, '0},
    '{1'b0, 32'hFFFF_FFFF, '{32'h1234_5678, 16'h0000, 16'h0000, 1'b1}, 1'b1, '{16'h0000, 16'h0000, 1'b1}},
    '{1'b0, 32'hFFFF_FFFF, '{32'h0000_0401, 16'h5A5A, 16'hA5A5, 1'b0}, 1'b0, '0}
  };

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_wr_en;
  logic [STEP_WIDTH-1:0] cfg_wr_data;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_W-1:0]       in_tdata;   // sample_index, in_i, in_q, zero pad
  logic                  in_tlast;   // terminating
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_W-1:0]      out_tdata;  // out_i, out_q, zero pad
  logic                  out_tlast;  // end_of_stream

  // Local copy of the step register and of the oscillator table.
  logic [STEP_WIDTH-1:0] step_cfg;
  int                    osc_sine [TBL_N];

  mixed_t mixed_due [$];
  bit     tx_burst;
  bit     rx_burst;
  int     rx_wait;
  int     idle_cycles;
  int     n_sent;
  int     n_eos;
  int     n_checked;
  int     n_errors;
  int     n_steps;

  indexed_oscillator_iq_mixer DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Sine over the first quarter turn: order-11 series in Q30 with
  // truncating steps, then rounded half up to amplitude 32767.
  function automatic int osc_quarter(input int j);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    logic [63:0] v;
    x  = (64'(j) * 64'd1686629713) / 64'(TBL_QTR);
    x2 = (x * x) >> 30;
    t  = (64'd1 << 30) - x2 / 64'd110;
    t  = (64'd1 << 30) - ((x2 * t) >> 30) / 64'd72;
    t  = (64'd1 << 30) - ((x2 * t) >> 30) / 64'd42;
    t  = (64'd1 << 30) - ((x2 * t) >> 30) / 64'd20;
    t  = (64'd1 << 30) - ((x2 * t) >> 30) / 64'd6;
    s  = (x * t) >> 30;
    v  = (s * 64'd32767 + (64'd1 << 29)) >> 30;
    if (v > 64'd32767) begin
      v = 64'd32767;
    end
    return int'(v);
  endfunction

  // Round half up from Q2.30 to Q1.15 and clamp to the sample range.
  function automatic logic signed [SW-1:0] round_sat(input longint acc);
    longint r;
    r = (acc + 64'sd16384) >>> 15;
    if (r > 64'sd32767) begin
      r = 64'sd32767;
    end else if (r < -64'sd32768) begin
      r = -64'sd32768;
    end
    return r[SW-1:0];
  endfunction

  // Mixed result for one sample under the current step.
  function automatic mixed_t mix_sample(input sample_t smp);
    logic [STEP_WIDTH-1:0] phase;
    int                    addr;
    longint                s;
    longint                c;
    longint                a;
    longint                b;
    mixed_t                res;
    if (smp.last) begin
      res = '{smp.re, smp.im, 1'b1};
    end else begin
      phase  = smp.index * step_cfg;
      addr   = int'(phase[STEP_WIDTH-1 -: TBL_BITS]);
      s      = osc_sine[addr];
      c      = osc_sine[(addr + TBL_QTR) % TBL_N];
      a      = $signed(smp.re);
      b      = $signed(smp.im);
      res.re = round_sat(a * s - b * c);
      res.im = round_sat(a * c + b * s);
      res.eos = 1'b0;
    end
    return res;
  endfunction

  // Sample values lean towards the extremes now and then.
  function automatic logic [SW-1:0] draw_sample();
    case ($urandom_range(0, 15))
      0: begin
        return 16'h8000;
      end
      1: begin
        return 16'h7FFF;
      end
      2: begin
        return 16'h0000;
      end
      3: begin
        return 16'hFFFF;
      end
      default: begin
        return 16'($urandom);
      end
    endcase
  endfunction

  task automatic report_mismatch(input string what, input int want, input int got);
    if (n_errors < REPORT_MAX) begin
      $display("mismatch on %s of result %0d: expected %0d, got %0d",
               what, n_checked, want, got);
    end
    n_errors++;
  endtask

  // Offers one item after a random gap and books its expected result once
  // it has been taken.
  task automatic send_sample(input sample_t smp, input logic typed, input mixed_t typed_res);
    int gap;
    gap = tx_burst ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {smp.im, smp.re, smp.index};
    in_tlast  <= smp.last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    mixed_due.push_back(typed ? typed_res : mix_sample(smp));
    n_sent++;
    if (smp.last) begin
      n_eos++;
    end
  endtask

  // The step is only written once the pipeline has run dry.
  task automatic write_step(input logic [STEP_WIDTH-1:0] value);
    in_tvalid <= 1'b0;
    while (mixed_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    step_cfg  = value;
    n_steps++;
  endtask

  // Result side: random stall after each item taken.
  always @(posedge clk) begin
    if (!rst_n) begin
      rx_wait    = 0;
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        rx_wait = rx_burst ? 0 : $urandom_range(0, 6);
      end else if (rx_wait > 0) begin
        rx_wait--;
      end
      out_tready <= (rx_wait == 0);
    end
  end

  // Each result taken is compared with the oldest expectation.
  always @(posedge clk) begin : result_check
    mixed_t want;
    mixed_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got = '{out_tdata[SW-1:0], out_tdata[2*SW-1:SW], out_tlast};
      if (mixed_due.size() == 0) begin
        report_mismatch("unexpected item", 0, 1);
      end else begin
        want = mixed_due.pop_front();
        if (got.re !== want.re) begin
          report_mismatch("out_i", int'(want.re), int'(got.re));
        end
        if (got.im !== want.im) begin
          report_mismatch("out_q", int'(want.im), int'(got.im));
        end
        if (got.eos !== want.eos) begin
          report_mismatch("end_of_stream", int'(want.eos), int'(got.eos));
        end
      end
      n_checked++;
    end
  end

  // Ends the run if neither side moves for too long.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: no item moved for %0d cycles", IDLE_LIMIT);
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    logic [STEP_WIDTH-1:0]  phase_steps [N_PHASES];
    logic [INDEX_WIDTH-1:0] run_index;
    sample_t                smp;
    rst_n       = 1'b0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tlast    = 1'b0;
    step_cfg    = '0;

    // Oscillator table by quarter-wave symmetry.
    for (int k = 0; k < TBL_N; k++) begin
      case (k / TBL_QTR)
        0: begin
          osc_sine[k] = osc_quarter(k % TBL_QTR);
        end
        1: begin
          osc_sine[k] = osc_quarter(TBL_QTR - k % TBL_QTR);
        end
        2: begin
          osc_sine[k] = -osc_quarter(k % TBL_QTR);
        end
        default: begin
          osc_sine[k] = -osc_quarter(TBL_QTR - k % TBL_QTR);
        end
      endcase
    end

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table.
    for (int r = 0; r < DIR_N; r++) begin
      if (DIR_ROWS[r].set_step) begin
        write_step(DIR_ROWS[r].step);
      end
      send_sample(DIR_ROWS[r].smp, DIR_ROWS[r].typed, DIR_ROWS[r].res);
    end

    // Random runs of consecutive indexes, one phase per step setting.
    phase_steps = '{$urandom, 32'hFFFF_FFFF, 32'h0000_0000,
                    32'($urandom_range(1, 32'h003F_FFFF)), 32'h8000_0000, $urandom};
    for (int p = 0; p < N_PHASES; p++) begin
      write_step(phase_steps[p]);
      run_index = $urandom;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n % 40 == 0) begin
          tx_burst = ($urandom_range(0, 3) == 0);
          rx_burst = ($urandom_range(0, 3) == 0);
        end
        smp.index = ($urandom_range(0, 7) == 0) ? $urandom : run_index;
        smp.re    = draw_sample();
        smp.im    = draw_sample();
        smp.last  = ($urandom_range(0, 24) == 0);
        send_sample(smp, 1'b0, '0);
        // A new stream starts after an end-of-stream sample.
        run_index = smp.last ? $urandom : run_index + 1;
      end
    end

    in_tvalid <= 1'b0;
    while (mixed_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d samples mixed, %0d of them end-of-stream, under %0d step settings.",
             n_sent, n_eos, n_steps);
    $display("%0d results compared, %0d field mismatches.", n_checked, n_errors);
    if (n_errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
